// ----- rtl/power_fault_guard_macros.svh -----
// Assertion macros for the power fault guard checker.
`ifndef POWER_FAULT_GUARD_MACROS_SVH
`define POWER_FAULT_GUARD_MACROS_SVH

// Checked only while out of reset.
`define PFG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define PFG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/pfg_pkg.sv -----
// Types and constants shared by the power fault guard modules.
`timescale 1ns / 1ps
package pfg_pkg;

  typedef struct packed {
    logic signed [15:0] sample_current;
    logic [15:0]        sample_voltage;
    logic [31:0]        sample_time;
  } sample_t;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_OVER  = 2'd1,
    FAULT_UNDER = 2'd2
  } fault_e;

  typedef struct packed {
    fault_e             fault_event;
    logic signed [15:0] smoothed_current;
  } result_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;

  localparam logic [CfgIdxW-1:0] CFG_FILTER_COEF = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_OC_LIMIT    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_OC_HOLD     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_UV_LIMIT    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_UV_HOLD     = 3'd4;

  localparam logic [16:0]        COEF_ONE        = 17'd65536;
  localparam logic signed [15:0] OC_LIMIT_RST    = 16'sd32767;
  localparam logic [15:0]        HOLD_RST        = 16'd100;
  localparam logic [15:0]        UV_LIMIT_RST    = 16'd0;
  localparam logic [15:0]        UV_FLOOR_MV     = 16'd500;

endpackage

// ----- rtl/pfg_ema.sv -----
// Exponential current smoother with Q16.16 state and rounded output.
`timescale 1ns / 1ps
module pfg_ema import pfg_pkg::*; #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic signed [15:0]   current_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [16:0]          coef_i,
  output logic signed [31:0]   filt_o,
  output logic signed [15:0]   smooth_o
);

  logic                 seen_q;
  logic [TIME_BITS-1:0] prev_time_q;
  logic signed [31:0]   filt_q;

  logic [16:0]        coef;
  logic signed [17:0] coef_s;
  logic signed [31:0] raw_q16;
  logic signed [32:0] diff;
  logic signed [50:0] prod;
  logic signed [50:0] prod_rnd;
  logic signed [34:0] sum;
  logic signed [32:0] out_rnd;
  logic signed [16:0] out_whole;

  always_comb begin
    coef     = (coef_i > COEF_ONE) ? COEF_ONE : coef_i;
    coef_s   = $signed({1'b0, coef});
    raw_q16  = {current_i, 16'h0000};
    diff     = 33'(raw_q16) - 33'(filt_q);
    prod     = diff * coef_s;
    prod_rnd = prod + 51'sd32768;
    sum      = 35'(filt_q) + prod_rnd[50:16];
    if (!seen_q || now_i == prev_time_q) begin
      filt_o = raw_q16;
    end else begin
      filt_o = sum[31:0];
    end
    out_rnd   = 33'(filt_o) + 33'sd32768;
    out_whole = out_rnd[32:16];
    if (out_whole[16] != out_whole[15]) begin
      smooth_o = out_whole[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      smooth_o = out_whole[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      prev_time_q <= '0;
      filt_q      <= '0;
    end else if (step_i) begin
      seen_q      <= 1'b1;
      prev_time_q <= now_i;
      filt_q      <= filt_o;
    end
  end

endmodule

// ----- rtl/pfg_trip.sv -----
// Persistence timer and one-shot latch for one fault condition.
`timescale 1ns / 1ps
module pfg_trip import pfg_pkg::*; #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 cond_i,
  input  logic                 allow_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [15:0]          hold_i,
  output logic                 fire_o
);

  logic                 pending_q, pending_d;
  logic                 latched_q, latched_d;
  logic [TIME_BITS-1:0] start_q, start_d;
  logic [TIME_BITS-1:0] elapsed;

  always_comb begin
    start_d   = pending_q ? start_q : now_i;
    elapsed   = now_i - start_d;
    fire_o    = cond_i && !latched_q && allow_i && (elapsed >= TIME_BITS'(hold_i));
    pending_d = cond_i;
    latched_d = cond_i && (latched_q || fire_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      latched_q <= 1'b0;
      start_q   <= '0;
    end else if (step_i) begin
      pending_q <= pending_d;
      latched_q <= latched_d;
      if (cond_i) begin
        start_q <= start_d;
      end
    end
  end

endmodule

// ----- rtl/power_fault_guard.sv -----
// Power fault guard top level: handshake registers, config registers, trip logic.
// One sample is taken per clock while the output is not stalled; a result passes
// from the input register through the smoothing multiply-add and the two trip
// timers into the result register. Throughput is one sample per cycle while the
// output is not stalled, set by that single compute stage, whose state updates as
// each result is registered. Configuration writes take effect on the next sample.
`timescale 1ns / 1ps
module power_fault_guard import pfg_pkg::*; #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sample_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output result_t             out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  logic [16:0]        coef_q;
  logic signed [15:0] oc_limit_q;
  logic [15:0]        oc_hold_q;
  logic [15:0]        uv_limit_q;
  logic [15:0]        uv_hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q     <= COEF_ONE;
      oc_limit_q <= OC_LIMIT_RST;
      oc_hold_q  <= HOLD_RST;
      uv_limit_q <= UV_LIMIT_RST;
      uv_hold_q  <= HOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FILTER_COEF: coef_q     <= cfg_wdata_i;
        CFG_OC_LIMIT:    oc_limit_q <= cfg_wdata_i[15:0];
        CFG_OC_HOLD:     oc_hold_q  <= cfg_wdata_i[15:0];
        CFG_UV_LIMIT:    uv_limit_q <= cfg_wdata_i[15:0];
        CFG_UV_HOLD:     uv_hold_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Input register and result register.
  logic    in_valid_q, in_valid_d;
  sample_t in_q;
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;
  logic    step;
  logic    in_xfer;

  assign step        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !step;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign in_valid_d  = in_xfer || (in_valid_q && !step);
  assign out_valid_d = step || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= out_d;
    end
  end

  // Compute stage.
  logic [TIME_BITS-1:0] now;
  logic signed [31:0]   filt;
  logic signed [15:0]   smooth;
  logic signed [31:0]   oc_thresh;
  logic                 over_cond;
  logic                 under_cond;
  logic                 over_fire;
  logic                 under_fire;

  assign now        = TIME_BITS'(in_q.sample_time);
  assign oc_thresh  = {oc_limit_q, 16'h0000};
  assign over_cond  = filt > oc_thresh;
  assign under_cond = (uv_limit_q != '0) && (in_q.sample_voltage > UV_FLOOR_MV)
                      && (in_q.sample_voltage < uv_limit_q);

  pfg_ema #(.TIME_BITS(TIME_BITS)) u_ema (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .current_i(in_q.sample_current),
    .now_i    (now),
    .coef_i   (coef_q),
    .filt_o   (filt),
    .smooth_o (smooth)
  );

  pfg_trip #(.TIME_BITS(TIME_BITS)) u_trip_over (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cond_i (over_cond),
    .allow_i(1'b1),
    .now_i  (now),
    .hold_i (oc_hold_q),
    .fire_o (over_fire)
  );

  // Overcurrent takes precedence in the same sample.
  pfg_trip #(.TIME_BITS(TIME_BITS)) u_trip_under (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cond_i (under_cond),
    .allow_i(!over_fire),
    .now_i  (now),
    .hold_i (uv_hold_q),
    .fire_o (under_fire)
  );

  always_comb begin
    out_d.smoothed_current = smooth;
    if (over_fire) begin
      out_d.fault_event = FAULT_OVER;
    end else if (under_fire) begin
      out_d.fault_event = FAULT_UNDER;
    end else begin
      out_d.fault_event = FAULT_NONE;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/pfg_checker.sv -----
// Port-level checks for the power fault guard, bound to the top level.
`timescale 1ns / 1ps
`include "power_fault_guard_macros.svh"
module pfg_checker import pfg_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_stall_o,
  input logic    out_valid_o,
  input logic    out_stall_i,
  input result_t out_data_o
);

  `PFG_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "result changed while stalled")
  `PFG_ASSERT(a_no_stall_empty, !out_valid_o |-> !in_stall_o, "input stalled with empty result register")
  `PFG_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !out_valid_o, "result valid during reset")

endmodule

bind power_fault_guard pfg_checker u_pfg_checker (.*);
